@@ rtl/hlfr_pkg.sv @@
`default_nettype none

package hlfr_pkg;

	// header byte is base + payload length
	localparam logic [7:0] HDR_BASE = 8'h80;
	localparam logic [7:0] HDR_FIRST = 8'h81;
	// header, target and source bytes counted ahead of the payload
	localparam int unsigned OVERHEAD_TAKEN = 3;
	localparam int unsigned MAX_PAYLOAD_DEF = 7;

	localparam int unsigned POS_W = 4;
	localparam int unsigned PLEN_W = 3;

	typedef struct packed {
		logic              accepted;
		logic [POS_W-1:0]  position;
		logic [7:0]        data_byte;
		logic              frame_done;
		logic              checksum_ok;
		logic [PLEN_W-1:0] payload_length;
	} hlfr_result_t;

endpackage

`default_nettype wire

@@ rtl/hlfr_decode.sv @@
`default_nettype none

module hlfr_decode #(
	parameter int unsigned MAX_PAYLOAD = hlfr_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1),
	parameter int unsigned IDX_W = $clog2(MAX_PAYLOAD + hlfr_pkg::OVERHEAD_TAKEN + 1)
) (
	input  wire logic [7:0]       rx_byte,
	input  wire logic [IDX_W-1:0] idx,
	input  wire logic [LEN_W-1:0] len,
	input  wire logic [7:0]       sum,
	output hlfr_pkg::hlfr_result_t result,
	output logic [IDX_W-1:0]      idx_next,
	output logic [LEN_W-1:0]      len_next,
	output logic [7:0]            sum_next
);
	import hlfr_pkg::*;

	localparam logic [7:0] HDR_LAST = 8'(HDR_BASE + MAX_PAYLOAD);

	logic             is_hdr;
	logic [LEN_W-1:0] hdr_len;
	logic [IDX_W-1:0] limit;

	assign is_hdr = (rx_byte >= HDR_FIRST) && (rx_byte <= HDR_LAST);
	assign hdr_len = LEN_W'(rx_byte - HDR_BASE);
	assign limit = IDX_W'(len) + IDX_W'(OVERHEAD_TAKEN);

	always_comb begin
		result = '0;
		result.data_byte = rx_byte;
		idx_next = idx;
		len_next = len;
		sum_next = sum;
		if (idx == '0) begin
			// idle: only a header byte opens a frame
			if (is_hdr) begin
				result.accepted = 1'b1;
				result.payload_length = PLEN_W'(hdr_len);
				len_next = hdr_len;
				sum_next = rx_byte;
				idx_next = IDX_W'(1);
			end
		end else begin
			result.payload_length = PLEN_W'(len);
			if (idx < limit) begin
				result.accepted = 1'b1;
				result.position = POS_W'(idx);
				sum_next = sum + rx_byte;
				idx_next = idx + IDX_W'(1);
			end else begin
				// checksum byte closes the frame
				result.frame_done = 1'b1;
				result.checksum_ok = (sum == rx_byte);
				idx_next = '0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/header_length_frame_receiver.sv @@
`default_nettype none

// an accepted input beat is held in the input register and decoded, and its result beat is
// then offered from the result register
// throughput: one byte per cycle, sustained, with no stalls on the output side
// the frame state (index, length, sum) advances as a byte leaves the input register
// reset (arst_n low, asynchronous) empties both registers and returns to idle
module header_length_frame_receiver #(
	parameter int unsigned MAX_PAYLOAD = hlfr_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [7:0]                   rx_byte,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              accepted,
	output logic [hlfr_pkg::POS_W-1:0]        position,
	output logic [7:0]                        data_byte,
	output logic                              frame_done,
	output logic                              checksum_ok,
	output logic [hlfr_pkg::PLEN_W-1:0]       payload_length
);
	import hlfr_pkg::*;

	// length field needs to hold MAX_PAYLOAD, index needs to reach length + overhead
	localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
	localparam int unsigned IDX_W = $clog2(MAX_PAYLOAD + OVERHEAD_TAKEN + 1);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// frame state; index zero means idle
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;
	logic [7:0]       sum_q;

	// result register
	logic         valid_s2;
	hlfr_result_t result_s2;

	hlfr_result_t     result;
	logic [IDX_W-1:0] idx_next;
	logic [LEN_W-1:0] len_next;
	logic [7:0]       sum_next;
	logic             out_free;
	logic             step;

	// result register can load when empty or being drained this cycle
	assign out_free = !valid_s2 || out_ready;
	// a byte is decoded and the frame state moves on
	assign step = valid_s1 && out_free;
	// input register can load when empty or its byte moves on
	assign in_ready = !valid_s1 || out_free;

	hlfr_decode #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.LEN_W(LEN_W),
		.IDX_W(IDX_W)
	) u_decode (
		.rx_byte(byte_s1),
		.idx(idx_q),
		.len(len_q),
		.sum(sum_q),
		.result(result),
		.idx_next(idx_next),
		.len_next(len_next),
		.sum_next(sum_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			idx_q <= '0;
			len_q <= '0;
			sum_q <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				idx_q <= idx_next;
				len_q <= len_next;
				sum_q <= sum_next;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= rx_byte;
		end
		if (step) begin
			result_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign accepted = result_s2.accepted;
	assign position = result_s2.position;
	assign data_byte = result_s2.data_byte;
	assign frame_done = result_s2.frame_done;
	assign checksum_ok = result_s2.checksum_ok;
	assign payload_length = result_s2.payload_length;

endmodule

`default_nettype wire

@@ tb/frame_checker.sv @@
`timescale 1ns / 1ps

module frame_checker #(
	parameter int unsigned MAX_PAYLOAD = hlfr_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic                        accepted,
	input  logic [hlfr_pkg::POS_W-1:0]  position,
	input  logic [7:0]                  data_byte,
	input  logic                        frame_done,
	input  logic                        checksum_ok,
	input  logic [hlfr_pkg::PLEN_W-1:0] payload_length,
	output int                          mismatch_count,
	output int                          results_pending
);
	import hlfr_pkg::*;

	// mirror of the receiver's frame state
	logic [3:0] frame_index;
	logic [3:0] frame_len;
	logic [7:0] frame_sum;

	hlfr_result_t expected_results[$];

	function automatic hlfr_result_t decode_byte(input logic [7:0] b);
		hlfr_result_t r;
		r = '0;
		r.data_byte = b;
		if (frame_index == 4'd0) begin
			if (b >= HDR_FIRST && int'(b) <= int'(HDR_BASE) + int'(MAX_PAYLOAD)) begin
				frame_len = 4'(b - HDR_BASE);
				frame_sum = b;
				frame_index = 4'd1;
				r.accepted = 1'b1;
				r.payload_length = PLEN_W'(frame_len);
			end
		end else begin
			r.payload_length = PLEN_W'(frame_len);
			if (int'(frame_index) < int'(frame_len) + int'(OVERHEAD_TAKEN)) begin
				r.accepted = 1'b1;
				r.position = POS_W'(frame_index);
				frame_sum = frame_sum + b;
				frame_index = frame_index + 4'd1;
			end else begin
				// checksum byte closes the frame either way
				r.frame_done = 1'b1;
				r.checksum_ok = (frame_sum == b);
				frame_index = 4'd0;
			end
		end
		return r;
	endfunction

	function automatic string show(input hlfr_result_t r);
		return {$sformatf("accepted=%0d position=%0d data_byte=%02h",
				r.accepted, r.position, r.data_byte),
			$sformatf(" frame_done=%0d checksum_ok=%0d payload_length=%0d",
				r.frame_done, r.checksum_ok, r.payload_length)};
	endfunction

	always @(posedge clk or negedge arst_n) begin
		hlfr_result_t seen;
		hlfr_result_t want;
		if (!arst_n) begin
			frame_index = '0;
			frame_len = '0;
			frame_sum = '0;
			expected_results.delete();
			mismatch_count = 0;
			results_pending = 0;
		end else begin
			// a result leaving now cannot stem from a byte entering at this edge
			if (out_valid && out_ready) begin
				seen = '{accepted, position, data_byte, frame_done, checksum_ok,
					payload_length};
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %s",
						$time, show(seen));
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						$display("%0t: result mismatch, expected %s, actual %s",
							$time, show(want), show(seen));
						mismatch_count++;
					end
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(decode_byte(rx_byte));
			results_pending = expected_results.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import hlfr_pkg::*;

	// stimulus volume and run bounds
	localparam int unsigned BYTE_TARGET = 1000;
	// from here on neither side idles
	localparam int unsigned CALM_FROM = 850;
	// worst case per byte adds a sender gap, a receiver stall and the pipeline latency
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_CYCLES = 10;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_ready;
	logic [7:0]        rx_byte;
	logic              out_valid;
	logic              out_ready;
	logic              accepted;
	logic [POS_W-1:0]  position;
	logic [7:0]        data_byte;
	logic              frame_done;
	logic              checksum_ok;
	logic [PLEN_W-1:0] payload_length;

	int          mismatch_count;
	int          results_pending;
	int unsigned bytes_sent;
	int unsigned cycle_count;
	// calm: end of run, no idling on either side
	bit          calm;
	// sender_quiet: a stretch of back-to-back input beats
	bit          sender_quiet;

	header_length_frame_receiver DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.position(position),
		.data_byte(data_byte),
		.frame_done(frame_done),
		.checksum_ok(checksum_ok),
		.payload_length(payload_length)
	);

	frame_checker frame_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.position(position),
		.data_byte(data_byte),
		.frame_done(frame_done),
		.checksum_ok(checksum_ok),
		.payload_length(payload_length),
		.mismatch_count(mismatch_count),
		.results_pending(results_pending)
	);

	// 10 ns clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// watchdog on total run length
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// receiver side: random stall bursts, toggling between stalling and
	// free-running stretches; no new stall bursts begin once the run is calm
	initial begin
		int  stall_left;
		bit  stall_mode;
		stall_left = 0;
		stall_mode = 1'b1;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				stall_mode = !stall_mode;
			if (stall_left > 0)
				stall_left--;
			else if (stall_mode && !calm && $urandom_range(0, 5) == 0)
				stall_left = $urandom_range(1, 15);
			out_ready <= (stall_left == 0);
		end
	end

	// one input beat: optional idle burst first, then hold valid until taken;
	// called and returns at a falling edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		if (!calm && !sender_quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 15);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// full frame with random addresses and payload; the checksum byte is
	// either the true sum or a corrupted one
	task automatic send_frame(input int unsigned len, input bit good_sum);
		logic [7:0] sum;
		logic [7:0] b;
		b = HDR_BASE + 8'(len);
		sum = b;
		send_byte(b);
		repeat (len + OVERHEAD_TAKEN - 1) begin
			b = 8'($urandom);
			sum = sum + b;
			send_byte(b);
		end
		if (good_sum)
			send_byte(sum);
		else
			send_byte(sum ^ 8'($urandom_range(1, 255)));
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		bytes_sent = 0;
		calm = 1'b0;
		sender_quiet = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// idle bytes that are not headers: zero, the base value just below the
		// first header, one past the largest header, all ones, top of ascii
		send_byte(8'h00);
		send_byte(HDR_BASE);
		send_byte(8'h88);
		send_byte(8'hFF);
		send_byte(8'h7F);
		// shortest frame, all-ones addresses so the sum wraps, a payload byte
		// that looks like a header, correct checksum
		send_byte(HDR_FIRST);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h85);
		send_byte(8'h04);
		// longest frame with a bad checksum, then the longest with a good one
		send_frame(MAX_PAYLOAD_DEF, 1'b0);
		send_frame(MAX_PAYLOAD_DEF, 1'b1);

		// random part: mostly well-formed frames, some with bad checksums,
		// mixed with idle noise
		while (bytes_sent < BYTE_TARGET) begin
			if (bytes_sent >= CALM_FROM)
				calm = 1'b1;
			sender_quiet = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: send_byte(8'($urandom_range(0, 8'h80)));
				1: send_byte(8'($urandom));
				default: send_frame($urandom_range(1, MAX_PAYLOAD_DEF),
					$urandom_range(0, 3) != 0);
			endcase
		end
		in_valid <= 1'b0;

		// let every expected result drain, then allow for pipeline latency
		while (results_pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && results_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

@@ files.f @@
rtl/hlfr_pkg.sv
rtl/hlfr_decode.sv
rtl/header_length_frame_receiver.sv
tb/frame_checker.sv
tb/testbench.sv
